// ===== src/aes128_pkg.sv =====
// Shared types, constants and AES round functions for the AES-128 encryption pipeline.
package aes128_pkg;

   localparam int NUM_ROUNDS  = 10;
   localparam int BLOCK_WIDTH = 128;
   localparam int HALF_WIDTH  = 64;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_LOW  = 2'd1;

   // Reduction constant of the field polynomial x^8+x^4+x^3+x+1.
   localparam logic [7:0] GF_REDUCE = 8'h1b;

   // Round constants for the key schedule, round 1 first.
   localparam logic [7:0] RCON_TABLE [NUM_ROUNDS] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

   // Forward substitution box.
   localparam logic [7:0] SBOX_TABLE [256] = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   // Block and round key that travel together from cell to cell.
   typedef struct packed {
      logic [BLOCK_WIDTH-1:0] state;
      logic [BLOCK_WIDTH-1:0] round_key;
   } aes128_stage_type;

   // Byte i of a block sits in the most significant bits first.
   function automatic logic [7:0] get_byte(input logic [BLOCK_WIDTH-1:0] blk, input int i);
      return blk[BLOCK_WIDTH-1-8*i -: 8];
   endfunction

   function automatic logic [7:0] times_x(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? GF_REDUCE : 8'h00);
   endfunction

   // SubBytes followed by ShiftRows; byte index is row + 4 * column.
   function automatic logic [BLOCK_WIDTH-1:0] sub_shift(input logic [BLOCK_WIDTH-1:0] blk);
      logic [BLOCK_WIDTH-1:0] res;
      res = '0;
      for (int row = 0; row < 4; row++) begin
         for (int col = 0; col < 4; col++) begin
            res[BLOCK_WIDTH-1-8*(row+4*col) -: 8] =
               SBOX_TABLE[get_byte(blk, row + 4 * ((col + row) % 4))];
         end
      end
      return res;
   endfunction

   // MixColumns on all four columns.
   function automatic logic [BLOCK_WIDTH-1:0] mix_columns(input logic [BLOCK_WIDTH-1:0] blk);
      logic [BLOCK_WIDTH-1:0] res;
      logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
      res = '0;
      for (int col = 0; col < 4; col++) begin
         a0 = get_byte(blk, 4 * col);
         a1 = get_byte(blk, 4 * col + 1);
         a2 = get_byte(blk, 4 * col + 2);
         a3 = get_byte(blk, 4 * col + 3);
         d0 = times_x(a0);
         d1 = times_x(a1);
         d2 = times_x(a2);
         d3 = times_x(a3);
         res[BLOCK_WIDTH-1-8*(4*col)   -: 8] = d0 ^ d1 ^ a1 ^ a2 ^ a3;
         res[BLOCK_WIDTH-1-8*(4*col+1) -: 8] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
         res[BLOCK_WIDTH-1-8*(4*col+2) -: 8] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
         res[BLOCK_WIDTH-1-8*(4*col+3) -: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
      end
      return res;
   endfunction

   // One step of the key schedule: next round key from the current one.
   function automatic logic [BLOCK_WIDTH-1:0] next_round_key(
      input logic [BLOCK_WIDTH-1:0] key,
      input logic [7:0]             rcon
   );
      logic [7:0] nxt [16];
      logic [BLOCK_WIDTH-1:0] res;
      nxt[0] = get_byte(key, 0) ^ SBOX_TABLE[get_byte(key, 13)] ^ rcon;
      nxt[1] = get_byte(key, 1) ^ SBOX_TABLE[get_byte(key, 14)];
      nxt[2] = get_byte(key, 2) ^ SBOX_TABLE[get_byte(key, 15)];
      nxt[3] = get_byte(key, 3) ^ SBOX_TABLE[get_byte(key, 12)];
      for (int j = 4; j < 16; j++) begin
         nxt[j] = get_byte(key, j) ^ nxt[j-4];
      end
      res = '0;
      for (int j = 0; j < 16; j++) begin
         res[BLOCK_WIDTH-1-8*j -: 8] = nxt[j];
      end
      return res;
   endfunction

endpackage

// ===== src/aes128_cell.sv =====
// One round cell: a full AES round plus one key schedule step, with its own pipeline register.
module aes128_cell
   import aes128_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       rcon,
   input  logic             mix_enable,
   input  logic             in_valid,
   output logic             in_ready,
   input  aes128_stage_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output aes128_stage_type out_data
);

   logic             valid_ff;
   aes128_stage_type data_ff;
   aes128_stage_type data_in;
   logic [BLOCK_WIDTH-1:0] shifted;
   logic             load;

   // The cell takes a new request when it is empty or its content moves on.
   assign load     = !valid_ff || out_ready;
   assign in_ready = load;

   // Round logic: derive this round's key, then SubBytes, ShiftRows, MixColumns when enabled, AddRoundKey.
   always_comb begin
      data_in.round_key = next_round_key(in_data.round_key, rcon);
      shifted = sub_shift(in_data.state);
      if (mix_enable) begin
         shifted = mix_columns(shifted);
      end
      data_in.state = shifted ^ data_in.round_key;
   end

   // Occupancy flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   // Payload register.
   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== src/aes128_block_encrypt_top.sv =====
// Top level of the AES-128 ECB encryption pipeline with its key registers.
// AES-128 encryption in codebook mode: one 128-bit block in, one ciphertext block out,
// under the key written through the csr port (index 0 key bytes 0 to 7, index 1 key
// bytes 8 to 15; other indexes are ignored). The datapath is an entry register that
// adds the initial key followed by a row of ten round cells; each cell holds one block
// together with its round key and derives the next round key on the fly, so a key
// write applies to the very next request. A request passes through the entry register and
// then the ten round cells in turn to its result, and the row accepts one request
// per cycle; any cell that is empty or moving takes new data, so a stalled result only
// blocks requests once all eleven registers are full.
module aes128_block_encrypt_top
   import aes128_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // Request channel.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [BLOCK_WIDTH-1:0]     req_tdata,  // [63:0] plaintext_high, [127:64] plaintext_low
   // Result channel.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [BLOCK_WIDTH-1:0]     rsp_tdata,  // [63:0] ciphertext_high, [127:64] ciphertext_low
   // Configuration write channel.
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [HALF_WIDTH-1:0]      csr_data
);

   logic [HALF_WIDTH-1:0] key_high_ff, key_high_in;
   logic [HALF_WIDTH-1:0] key_low_ff, key_low_in;
   logic [BLOCK_WIDTH-1:0] key_block;
   logic [BLOCK_WIDTH-1:0] plain_block;

   logic             entry_valid_ff;
   aes128_stage_type entry_data_ff;
   aes128_stage_type entry_data_in;
   logic             entry_load;

   logic             cell_valid [NUM_ROUNDS+1];
   logic             cell_ready [NUM_ROUNDS+1];
   aes128_stage_type cell_data  [NUM_ROUNDS+1];

   // Key register writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_KEY_HIGH: key_high_in = csr_data;
            CSR_KEY_LOW:  key_low_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
      end
   end

   // Entry register: initial AddRoundKey, round key 0 travels along.
   assign key_block   = {key_high_ff, key_low_ff};
   assign plain_block = {req_tdata[HALF_WIDTH-1:0], req_tdata[BLOCK_WIDTH-1:HALF_WIDTH]};
   assign entry_load  = !entry_valid_ff || cell_ready[0];
   assign req_tready  = entry_load;

   always_comb begin
      entry_data_in.state     = plain_block ^ key_block;
      entry_data_in.round_key = key_block;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (entry_load) begin
         entry_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (entry_load && req_tvalid) begin
         entry_data_ff <= entry_data_in;
      end
   end

   assign cell_valid[0] = entry_valid_ff;
   assign cell_data[0]  = entry_data_ff;

   // Row of round cells; the last round skips MixColumns.
   for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
      aes128_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .rcon       (RCON_TABLE[r]),
         .mix_enable (r != NUM_ROUNDS - 1),
         .in_valid   (cell_valid[r]),
         .in_ready   (cell_ready[r]),
         .in_data    (cell_data[r]),
         .out_valid  (cell_valid[r+1]),
         .out_ready  (cell_ready[r+1]),
         .out_data   (cell_data[r+1])
      );
   end

   // Result from the last cell.
   assign cell_ready[NUM_ROUNDS] = rsp_tready;
   assign rsp_tvalid = cell_valid[NUM_ROUNDS];
   assign rsp_tdata  = {cell_data[NUM_ROUNDS].state[HALF_WIDTH-1:0],
                        cell_data[NUM_ROUNDS].state[BLOCK_WIDTH-1:HALF_WIDTH]};

endmodule

// ===== verif/aes128_block_encrypt_checker.sv =====
// Watches the request, result and key channels, predicts each ciphertext and compares it.
module aes128_block_encrypt_checker
   import aes128_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [BLOCK_WIDTH-1:0]     req_tdata,  // [63:0] plaintext_high, [127:64] plaintext_low
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [BLOCK_WIDTH-1:0]     rsp_tdata,  // [63:0] ciphertext_high, [127:64] ciphertext_low
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [HALF_WIDTH-1:0]      csr_data,
   output int                         fail_count,
   output int                         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         CIPHER_ROUNDS = 10;
   localparam logic [7:0] FIELD_POLY    = 8'h1b;
   localparam logic [7:0] AFFINE_CONST  = 8'h63;
   localparam int         REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [HALF_WIDTH-1:0] ct_high;
      logic [HALF_WIDTH-1:0] ct_low;
   } cipher_result_type;

   logic [7:0]             sbox [256];
   logic [HALF_WIDTH-1:0]  key_high_q;
   logic [HALF_WIDTH-1:0]  key_low_q;
   logic [BLOCK_WIDTH-1:0] sched_keys [CIPHER_ROUNDS+1];
   cipher_result_type      expected_ciphertexts [$];
   int                     mismatches = 0;

   function automatic logic [7:0] gf_double(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? FIELD_POLY : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      acc = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc = acc ^ x;
         x = gf_double(x);
      end
      return acc;
   endfunction

   // The substitution box is derived from the field inverse and the affine map,
   // so the prediction does not lean on the table inside the design.
   initial begin : build_sbox
      logic [7:0] b;
      for (int v = 0; v < 256; v++) begin
         b = 8'h00;
         for (int u = 1; u < 256; u++) begin
            if (gf_mult(v[7:0], u[7:0]) == 8'h01) b = u[7:0];
         end
         sbox[v] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                   ^ {b[3:0], b[7:4]} ^ AFFINE_CONST;
      end
   end

   // Key schedule: all eleven round keys from the two key halves.
   function automatic void refresh_sched_keys();
      logic [7:0]             w [16];
      logic [7:0]             n [16];
      logic [7:0]             rc;
      logic [BLOCK_WIDTH-1:0] key;
      key = {key_high_q, key_low_q};
      rc = 8'h01;
      for (int j = 0; j < 16; j++) w[j] = key[BLOCK_WIDTH-1-8*j -: 8];
      sched_keys[0] = key;
      for (int r = 1; r <= CIPHER_ROUNDS; r++) begin
         n[0] = w[0] ^ sbox[w[13]] ^ rc;
         n[1] = w[1] ^ sbox[w[14]];
         n[2] = w[2] ^ sbox[w[15]];
         n[3] = w[3] ^ sbox[w[12]];
         for (int j = 4; j < 16; j++) n[j] = w[j] ^ n[j-4];
         for (int j = 0; j < 16; j++) begin
            w[j] = n[j];
            sched_keys[r][BLOCK_WIDTH-1-8*j -: 8] = n[j];
         end
         rc = gf_double(rc);
      end
   endfunction

   // Full cipher on one block; byte 0 is the most significant byte of the block.
   function automatic cipher_result_type encrypt_block(input logic [BLOCK_WIDTH-1:0] blk);
      logic [7:0]             s [16];
      logic [7:0]             t [16];
      logic [7:0]             a0, a1, a2, a3;
      logic [BLOCK_WIDTH-1:0] ct;
      cipher_result_type      res;
      for (int i = 0; i < 16; i++) begin
         s[i] = blk[BLOCK_WIDTH-1-8*i -: 8] ^ sched_keys[0][BLOCK_WIDTH-1-8*i -: 8];
      end
      for (int r = 1; r <= CIPHER_ROUNDS; r++) begin
         // Byte substitution with the row rotation folded in.
         for (int row = 0; row < 4; row++) begin
            for (int col = 0; col < 4; col++) begin
               t[row + 4*col] = sbox[s[row + 4*((col + row) % 4)]];
            end
         end
         // Column mixing in every round but the last.
         if (r < CIPHER_ROUNDS) begin
            for (int col = 0; col < 4; col++) begin
               a0 = t[4*col];
               a1 = t[4*col+1];
               a2 = t[4*col+2];
               a3 = t[4*col+3];
               t[4*col]   = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
               t[4*col+1] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
               t[4*col+2] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
               t[4*col+3] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
            end
         end
         for (int i = 0; i < 16; i++) begin
            s[i] = t[i] ^ sched_keys[r][BLOCK_WIDTH-1-8*i -: 8];
         end
      end
      for (int i = 0; i < 16; i++) ct[BLOCK_WIDTH-1-8*i -: 8] = s[i];
      res.ct_high = ct[BLOCK_WIDTH-1 -: HALF_WIDTH];
      res.ct_low  = ct[HALF_WIDTH-1:0];
      return res;
   endfunction

   // Track key writes, queue a prediction per request and check each result.
   always @(posedge clock) begin
      cipher_result_type got;
      cipher_result_type want;
      if (reset) begin
         expected_ciphertexts.delete();
         key_high_q = '0;
         key_low_q  = '0;
         refresh_sched_keys();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KEY_HIGH: begin
                  key_high_q = csr_data;
                  refresh_sched_keys();
               end
               CSR_KEY_LOW: begin
                  key_low_q = csr_data;
                  refresh_sched_keys();
               end
               default: begin
                  // Writes to unused indexes leave the key alone.
               end
            endcase
         end
         // Results are matched before this edge's request is queued.
         if (rsp_tvalid && rsp_tready) begin
            got.ct_high = rsp_tdata[HALF_WIDTH-1:0];
            got.ct_low  = rsp_tdata[BLOCK_WIDTH-1:HALF_WIDTH];
            if (expected_ciphertexts.size() == 0) begin
               if (mismatches < REPORT_LIMIT) begin
                  $display("%0t: result with nothing pending: high %h low %h",
                           $realtime, got.ct_high, got.ct_low);
               end
               mismatches++;
            end else begin
               want = expected_ciphertexts.pop_front();
               if (got.ct_high !== want.ct_high) begin
                  if (mismatches < REPORT_LIMIT) begin
                     $display("%0t: ciphertext_high expected %h, got %h",
                              $realtime, want.ct_high, got.ct_high);
                  end
                  mismatches++;
               end
               if (got.ct_low !== want.ct_low) begin
                  if (mismatches < REPORT_LIMIT) begin
                     $display("%0t: ciphertext_low expected %h, got %h",
                              $realtime, want.ct_low, got.ct_low);
                  end
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_ciphertexts.push_back(
               encrypt_block({req_tdata[HALF_WIDTH-1:0], req_tdata[BLOCK_WIDTH-1:HALF_WIDTH]}));
         end
      end
      pending_count <= expected_ciphertexts.size();
      fail_count    <= mismatches;
   end

endmodule

// ===== verif/tb_aes128_block_encrypt_top.sv =====
// Stimulus and verdict for the AES-128 block encryption pipeline.
module tb_aes128_block_encrypt_top;
   import aes128_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int RANDOM_PHASES   = 8;
   localparam int SETTLE_CYCLES   = 4;
   localparam int DRAIN_CYCLES    = 24;

   // Indexes outside the register list; writes there must be ignored.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_B = 2'd3;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [BLOCK_WIDTH-1:0]     req_tdata;  // [63:0] plaintext_high, [127:64] plaintext_low
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [BLOCK_WIDTH-1:0]     rsp_tdata;  // [63:0] ciphertext_high, [127:64] ciphertext_low
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [HALF_WIDTH-1:0]      csr_data;

   int checker_fails;
   int checker_pending;
   int cycle_count = 0;
   bit send_gaps   = 1'b0;
   bit recv_gaps   = 1'b0;

   aes128_block_encrypt_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   aes128_block_encrypt_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (checker_fails),
      .pending_count (checker_pending)
   );

   always #5 clock = ~clock;

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_aes128_block_encrypt_top: done, errors");
         $finish;
      end
   end

   // Result side: ready drops in random bursts while stalls are enabled.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (recv_gaps && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Random 64-bit word with a bias toward the extremes and single-bit patterns.
   function automatic logic [HALF_WIDTH-1:0] pick_word();
      logic [HALF_WIDTH-1:0] one_hot;
      one_hot = 64'd1 << $urandom_range(0, HALF_WIDTH-1);
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         2:       return one_hot;
         3:       return ~one_hot;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Present one request, starting and ending at a falling edge.
   task automatic send_block(input logic [HALF_WIDTH-1:0] pt_high,
                             input logic [HALF_WIDTH-1:0] pt_low);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pt_low, pt_high};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop sending and wait until every predicted result has come back.
   task automatic drain(input int settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (checker_pending != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
      @(negedge clock);
   endtask

   // One key register write; the pipeline must be drained beforehand.
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [HALF_WIDTH-1:0]      value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int phase;
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_KEY_HIGH;
      csr_data   = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed blocks under the all-zero key left by reset.
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
      send_block('0, '0);
      send_block('1, '1);
      send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
      send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
      send_block(64'h8000000000000000, 64'h0000000000000001);
      drain(SETTLE_CYCLES);

      // Standard test vector key and plaintext, then the extremes of the data.
      write_csr(CSR_KEY_HIGH, 64'h0001020304050607);
      write_csr(CSR_KEY_LOW, 64'h08090a0b0c0d0e0f);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block('0, '0);
      send_block('1, '1);
      drain(SETTLE_CYCLES);

      // Writes to unused indexes must not disturb the key.
      write_csr(CSR_SPARE_A, '1);
      write_csr(CSR_SPARE_B, 64'h0123456789abcdef);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
      drain(SETTLE_CYCLES);

      // All-ones key, then a key change of only one half.
      write_csr(CSR_KEY_HIGH, '1);
      write_csr(CSR_KEY_LOW, '1);
      send_block('0, '0);
      send_block('1, '1);
      send_block(64'h0000000000000001, 64'h8000000000000000);
      drain(SETTLE_CYCLES);
      write_csr(CSR_KEY_LOW, '0);
      send_block('0, '1);
      send_block('1, '0);
      drain(SETTLE_CYCLES);

      // Random phases, each under a fresh key; the last one runs without gaps.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         send_gaps = (phase < RANDOM_PHASES - 1) && (phase != 3);
         recv_gaps = (phase < RANDOM_PHASES - 1);
         if ($urandom_range(0, 3) == 0) begin
            write_csr(CSR_KEY_LOW, pick_word());
         end else begin
            write_csr(CSR_KEY_HIGH, pick_word());
            write_csr(CSR_KEY_LOW, pick_word());
         end
         if ($urandom_range(0, 2) == 0) begin
            write_csr($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, pick_word());
         end
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            send_block(pick_word(), pick_word());
         end
         drain(SETTLE_CYCLES);
      end

      drain(DRAIN_CYCLES);
      if (checker_fails == 0) begin
         $display("tb_aes128_block_encrypt_top: done, clean");
      end else begin
         $display("tb_aes128_block_encrypt_top: done, errors");
      end
      $finish;
   end

endmodule
